FILE: hw/rtl/rcdv_pkg.sv
// rcdv_pkg: shared widths and the command/status types of the run-count
// difference variance block. No dependencies.
`default_nettype none

package rcdv_pkg;

   localparam int PIX_W  = 8;
   localparam int CNT_W  = 11;
   localparam int SUM_W  = 21;
   localparam int SQ_W   = 31;
   localparam int VAR_W  = 27;
   localparam int PROD_W = CNT_W + SQ_W;    // n * S2 and S1 * S1 both fit
   localparam int DEN_W  = 2 * CNT_W;       // n * n
   localparam int RUN_LIMIT = (1 << CNT_W) - 1;

   localparam int DEF_MAX_LINE_LEN = 1024;
   localparam int DEF_MAX_LINES    = 1024;
   localparam int DEF_FRAC_BITS    = 8;

   // controller to datapath
   typedef struct packed {
      logic px_accept;   // pixel transaction taken this cycle
      logic mul_load;    // form n*S2, S1^2, n^2
      logic sub_load;    // form dividend, decide skip
      logic div_step;    // one quotient bit
      logic out_load;    // move result into output register
   } rcdv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;        // fewer than two lines or no positive spread
   } rcdv_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rcdv_datapath.sv
// rcdv_datapath: run counting, difference sums, final products and the
// restoring divider, plus the result register. Uses rcdv_pkg.
`default_nettype none

module rcdv_datapath
   import rcdv_pkg::*;
#(
   parameter int MAX_LINE_LEN = DEF_MAX_LINE_LEN,
   parameter int MAX_LINES    = DEF_MAX_LINES,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rcdv_cmd_type       cmd,
   output rcdv_stat_type           stat,
   input  wire logic [PIX_W-1:0]   req_pixel,
   input  wire logic               req_line_end,
   input  wire logic               req_rect_end,
   output logic [VAR_W-1:0]        rsp_variance,
   output logic [CNT_W-1:0]        rsp_lines_counted,
   output logic                    rsp_status
);

   localparam int RUN_CAP  = (MAX_LINE_LEN < RUN_LIMIT) ? MAX_LINE_LEN : RUN_LIMIT;
   localparam int LINE_CAP = (MAX_LINES < RUN_LIMIT) ? MAX_LINES : RUN_LIMIT;
   localparam int NUM_W    = PROD_W + FRAC_BITS;
   localparam logic [NUM_W-1:0] VAR_MAX = NUM_W'({VAR_W{1'b1}});

   // streaming state
   logic [PIX_W-1:0] prev_px_ff;
   logic             started_ff;
   logic [CNT_W-1:0] runs_ff;
   logic [CNT_W-1:0] prev_runs_ff;
   logic [CNT_W-1:0] lines_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]  sq_ff;

   // rectangle snapshot and final arithmetic
   logic [CNT_W-1:0] snap_lines_ff;
   logic [SUM_W-1:0] snap_sum_ff;
   logic [SQ_W-1:0]  snap_sq_ff;
   logic [PROD_W-1:0] a_ff;
   logic [PROD_W-1:0] b_ff;
   logic [DEN_W-1:0]  nn_ff;
   logic              skip_ff;
   logic [NUM_W-1:0]  quot_ff;
   logic [DEN_W-1:0]  rem_ff;

   logic [VAR_W-1:0]  variance_ff;
   logic [CNT_W-1:0]  lines_out_ff;
   logic              status_ff;

   logic [CNT_W-1:0]  runs_in;
   logic              finish;
   logic [CNT_W-1:0]  diff;
   logic [DEN_W-1:0]  diff_sq;
   logic [SUM_W:0]    sum_ext;
   logic [SQ_W:0]     sq_ext;
   logic [CNT_W-1:0]  prev_runs_in;
   logic [CNT_W-1:0]  lines_in;
   logic [SUM_W-1:0]  sum_in;
   logic [SQ_W-1:0]   sq_in;
   logic [CNT_W-1:0]  n_val;
   logic              skip_now;
   logic [DEN_W:0]    rem_sh;
   logic              q_bit;

   always_comb begin
      if (!started_ff) begin
         runs_in = CNT_W'(1);
      end else if (req_pixel != prev_px_ff && runs_ff < CNT_W'(RUN_CAP)) begin
         runs_in = runs_ff + CNT_W'(1);
      end else begin
         runs_in = runs_ff;
      end
      finish = req_line_end | req_rect_end;
      diff = (runs_in >= prev_runs_ff) ? runs_in - prev_runs_ff : prev_runs_ff - runs_in;
      diff_sq = DEN_W'(diff) * DEN_W'(diff);
      sum_ext = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(diff);
      sq_ext  = (SQ_W+1)'(sq_ff) + (SQ_W+1)'(diff_sq);

      prev_runs_in = prev_runs_ff;
      lines_in     = lines_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      if (finish && lines_ff < CNT_W'(LINE_CAP)) begin
         if (lines_ff != '0) begin
            sum_in = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            sq_in  = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
         end
         prev_runs_in = runs_in;
         lines_in     = lines_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_px_ff   <= '0;
         started_ff   <= 1'b0;
         runs_ff      <= '0;
         prev_runs_ff <= '0;
         lines_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
      end else if (cmd.px_accept) begin
         if (req_rect_end) begin
            // rectangle closes, start the next one clean
            prev_px_ff   <= '0;
            started_ff   <= 1'b0;
            runs_ff      <= '0;
            prev_runs_ff <= '0;
            lines_ff     <= '0;
            sum_ff       <= '0;
            sq_ff        <= '0;
         end else begin
            prev_px_ff   <= req_pixel;
            started_ff   <= !finish;
            runs_ff      <= finish ? '0 : runs_in;
            prev_runs_ff <= prev_runs_in;
            lines_ff     <= lines_in;
            sum_ff       <= sum_in;
            sq_ff        <= sq_in;
         end
      end
   end

   assign n_val    = snap_lines_ff - CNT_W'(1);
   assign skip_now = (snap_lines_ff < CNT_W'(2)) || (a_ff <= b_ff);
   assign rem_sh   = {rem_ff, quot_ff[NUM_W-1]};
   assign q_bit    = (rem_sh >= (DEN_W+1)'(nn_ff));

   always_ff @(posedge clock) begin
      if (cmd.px_accept && req_rect_end) begin
         snap_lines_ff <= lines_in;
         snap_sum_ff   <= sum_in;
         snap_sq_ff    <= sq_in;
      end
      if (cmd.mul_load) begin
         a_ff  <= PROD_W'(n_val) * PROD_W'(snap_sq_ff);
         b_ff  <= PROD_W'(snap_sum_ff) * PROD_W'(snap_sum_ff);
         nn_ff <= DEN_W'(n_val) * DEN_W'(n_val);
      end
      if (cmd.sub_load) begin
         skip_ff <= skip_now;
         quot_ff <= NUM_W'(a_ff - b_ff) << FRAC_BITS;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= q_bit ? DEN_W'(rem_sh - (DEN_W+1)'(nn_ff)) : rem_sh[DEN_W-1:0];
         quot_ff <= {quot_ff[NUM_W-2:0], q_bit};
      end
      if (cmd.out_load) begin
         if (skip_ff) begin
            variance_ff <= '0;
         end else if (quot_ff > VAR_MAX) begin
            variance_ff <= {VAR_W{1'b1}};
         end else begin
            variance_ff <= quot_ff[VAR_W-1:0];
         end
         lines_out_ff <= snap_lines_ff;
         status_ff    <= (snap_lines_ff < CNT_W'(2));
      end
   end

   assign stat.skip         = skip_now;
   assign rsp_variance      = variance_ff;
   assign rsp_lines_counted = lines_out_ff;
   assign rsp_status        = status_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rcdv_ctrl.sv
// rcdv_ctrl: sequencer for pixel intake, final products, divide loop and
// result hand-off. Uses rcdv_pkg.
`default_nettype none

module rcdv_ctrl
   import rcdv_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_rect_end,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rcdv_cmd_type       cmd,
   input  wire rcdv_stat_type stat
);

   localparam int NUM_W   = PROD_W + FRAC_BITS;
   localparam int DCNT_W  = $clog2(NUM_W);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MUL,
      ST_SUB,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.px_accept = (state_ff == ST_ACCUM) && req_valid;
      cmd.mul_load  = (state_ff == ST_MUL);
      cmd.sub_load  = (state_ff == ST_SUB);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.out_load  = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces one leaving in the same cycle
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_ACCUM: begin
               if (req_valid && req_rect_end) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_SUB;
            end
            ST_SUB: begin
               div_cnt_ff <= '0;
               state_ff   <= stat.skip ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               if (div_cnt_ff == DCNT_W'(NUM_W - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // wait until the result register can take the new transaction
               if (out_free) begin
                  state_ff <= ST_ACCUM;
               end
            end
            default: begin
               state_ff <= ST_ACCUM;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/run_count_difference_variance_top.sv
// run_count_difference_variance_top: run-count difference variance block.
// Instantiates rcdv_ctrl and rcdv_datapath; uses rcdv_pkg.
//
// Usage:
//  - req channel carries one pixel per transaction with line_end and
//    rect_end markers; pixels are taken one per cycle while the block is
//    accumulating.
//  - a transaction with rect_end closes the rectangle. req_stall then rises
//    for the final arithmetic: the products, then the dividend, then a
//    one-bit-per-cycle restoring divider over a (42 + FRAC_BITS)-bit
//    dividend, then the load of the result register, after which
//    rsp_valid rises. Fewer than two lines or zero spread skip the
//    divider.
//  - the rsp channel gives variance, lines_counted and status; status 1
//    means fewer than two lines and the variance reads 0.
//  - the result sits in an output register: pixels of the next rectangle
//    are taken while it waits on rsp_stall; only a following result waits
//    in its final cycle until the register frees.
//  - reset (synchronous, active high) clears all counters and sums and
//    drops rsp_valid; no clearing pass is needed.
`default_nettype none

module run_count_difference_variance_top
   import rcdv_pkg::*;
#(
   parameter int MAX_LINE_LEN = DEF_MAX_LINE_LEN,
   parameter int MAX_LINES    = DEF_MAX_LINES,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PIX_W-1:0]  req_pixel,
   input  wire logic              req_line_end,
   input  wire logic              req_rect_end,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [VAR_W-1:0]       rsp_variance,
   output logic [CNT_W-1:0]       rsp_lines_counted,
   output logic                   rsp_status
);

   rcdv_cmd_type  cmd;
   rcdv_stat_type stat;

   rcdv_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_rect_end (req_rect_end),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .cmd          (cmd),
      .stat         (stat)
   );

   rcdv_datapath #(
      .MAX_LINE_LEN (MAX_LINE_LEN),
      .MAX_LINES    (MAX_LINES),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_pixel         (req_pixel),
      .req_line_end      (req_line_end),
      .req_rect_end      (req_rect_end),
      .rsp_variance      (rsp_variance),
      .rsp_lines_counted (rsp_lines_counted),
      .rsp_status        (rsp_status)
   );

   // closing a rectangle blocks further pixels for the final arithmetic
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_rect_end) |=> req_stall)
      else $error("pixel intake not held after rectangle end");

   // error status carries a zero variance
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_variance == '0))
      else $error("nonzero variance with error status");

   // status agrees with the line count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == (rsp_lines_counted < CNT_W'(2))))
      else $error("status does not match lines counted");

endmodule

`default_nettype wire

FILE: verif/run_count_difference_variance_top_tb.sv
// run_count_difference_variance_top_tb: self-checking bench for the run-count difference
// variance block; predicts every result in-bench and compares field by field.
// Depends on rcdv_pkg and run_count_difference_variance_top.
module run_count_difference_variance_top_tb;
   import rcdv_pkg::*;

   localparam int MAX_LINE_LEN = DEF_MAX_LINE_LEN;
   localparam int MAX_LINES    = DEF_MAX_LINES;
   localparam int FRAC_BITS    = DEF_FRAC_BITS;

   localparam int RUN_CAP  = (MAX_LINE_LEN < RUN_LIMIT) ? MAX_LINE_LEN : RUN_LIMIT;
   localparam int LINE_CAP = (MAX_LINES < RUN_LIMIT) ? MAX_LINES : RUN_LIMIT;
   localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;
   localparam longint unsigned SQ_MAX  = (64'd1 << SQ_W) - 1;
   localparam longint unsigned VAR_MAX = (64'd1 << VAR_W) - 1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_FEW_LINES = 1'b1;

   localparam int PHASE_ITEMS    = 230;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int LONG_LINE_LEN  = 1030;
   localparam int EXTRA_LINES    = 8;

   typedef struct packed {
      logic [VAR_W-1:0] variance;
      logic [CNT_W-1:0] lines;
      logic             status;
   } variance_result_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel;
      logic                line_end;
      logic                rect_end;
      logic                known;
      variance_result_type result;
   } directed_row_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             req_line_end = 1'b0;
   logic             req_rect_end = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [VAR_W-1:0] rsp_variance;
   logic [CNT_W-1:0] rsp_lines_counted;
   logic             rsp_status;

   run_count_difference_variance_top #(
      .MAX_LINE_LEN(MAX_LINE_LEN),
      .MAX_LINES   (MAX_LINES),
      .FRAC_BITS   (FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_line_end     (req_line_end),
      .req_rect_end     (req_rect_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_variance     (rsp_variance),
      .rsp_lines_counted(rsp_lines_counted),
      .rsp_status       (rsp_status)
   );

   // directed rows: single-line rectangles, flat lines, alternating bit patterns
   directed_row_type directed_rows [0:17] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, '{27'd0, 11'd1, STATUS_FEW_LINES}},
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{27'd0, 11'd1, STATUS_FEW_LINES}},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{27'd0, 11'd2, STATUS_OK}},
      '{8'h07, 1'b1, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b1, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, 1'b0, '0},
      '{8'h55, 1'b1, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b1, 1'b0, '0},
      '{8'h33, 1'b1, 1'b0, 1'b0, '0},
      '{8'h33, 1'b1, 1'b1, 1'b0, '0}
   };

   // predictor state
   logic [PIX_W-1:0] last_pixel;
   logic             in_line;
   logic [CNT_W-1:0] run_len;
   logic [CNT_W-1:0] prev_run_len;
   logic [CNT_W-1:0] line_total;
   logic [SUM_W-1:0] diff_sum;
   logic [SQ_W-1:0]  diff_sq_sum;

   variance_result_type variance_queue[$];

   int fail_count = 0;
   int sent_items = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic clear_rect_state();
      last_pixel   = '0;
      in_line      = 1'b0;
      run_len      = '0;
      prev_run_len = '0;
      line_total   = '0;
      diff_sum     = '0;
      diff_sq_sum  = '0;
   endtask

   task automatic accumulate_pixel(input logic [PIX_W-1:0] px, input logic le,
                                   input logic re, output bit got,
                                   output variance_result_type res);
      longint unsigned d, s, q, n, a, b, v;
      got = 1'b0;
      res = '0;
      if (!in_line) begin
         run_len = CNT_W'(1);
         in_line = 1'b1;
      end else if (px != last_pixel && run_len < RUN_CAP) begin
         run_len = run_len + 1'b1;
      end
      last_pixel = px;

      // rect end closes the current line as well
      if (le || re) begin
         if (line_total < LINE_CAP) begin
            if (line_total > 0) begin
               d = (run_len >= prev_run_len) ? longint'(run_len - prev_run_len)
                                             : longint'(prev_run_len - run_len);
               s = longint'(diff_sum) + d;
               q = longint'(diff_sq_sum) + d * d;
               diff_sum    = (s > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(s);
               diff_sq_sum = (q > SQ_MAX) ? SQ_W'(SQ_MAX) : SQ_W'(q);
            end
            prev_run_len = run_len;
            line_total   = line_total + 1'b1;
         end
         in_line = 1'b0;
         run_len = '0;
      end

      if (re) begin
         got = 1'b1;
         res.lines = line_total;
         if (line_total < 2) begin
            res.status = STATUS_FEW_LINES;
         end else begin
            res.status = STATUS_OK;
            n = longint'(line_total) - 1;
            a = n * longint'(diff_sq_sum);
            b = longint'(diff_sum) * longint'(diff_sum);
            if (a > b) begin
               v = ((a - b) << FRAC_BITS) / (n * n);
               if (v > VAR_MAX) v = VAR_MAX;
               res.variance = VAR_W'(v);
            end
         end
         clear_rect_state();
      end
   endtask

   task automatic drive_pixel(input logic [PIX_W-1:0] px, input logic le, input logic re,
                              input logic known, input variance_result_type known_res);
      int gap;
      bit got;
      variance_result_type pred;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel    <= px;
      req_line_end <= le;
      req_rect_end <= re;
      do @(posedge clock); while (req_stall);
      accumulate_pixel(px, le, re, got, pred);
      if (got) begin
         if (known) pred = known_res;
         variance_queue = {variance_queue, pred};
      end
      sent_items++;
   endtask

   // sender pauses until the block has handed back everything it owes
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (variance_queue.size() != 0);
   endtask

   task automatic send_random_rect();
      int n_lines, base_len, len;
      logic [PIX_W-1:0] pa, pb, px;
      logic last_pix, last_rect;
      if ($urandom_range(0, 4) == 0) begin
         // noise: arbitrary markers, rect end only at the close
         len = $urandom_range(1, 16);
         for (int k = 0; k < len; k++)
            drive_pixel(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                        k == len - 1, 1'b0, '0);
      end else begin
         n_lines  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         base_len = $urandom_range(1, 10);
         pa = PIX_W'($urandom_range(0, 255));
         pb = PIX_W'($urandom_range(0, 255));
         for (int l = 0; l < n_lines; l++) begin
            len = $urandom_range(1, base_len);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 2))
                  0:       px = PIX_W'($urandom_range(0, 255));
                  1:       px = pa;
                  default: px = pb;
               endcase
               last_pix  = (k == len - 1);
               last_rect = last_pix && (l == n_lines - 1);
               // rect end sometimes arrives without its line end
               drive_pixel(px, last_pix && !(last_rect && $urandom_range(0, 1)), last_rect,
                           1'b0, '0);
            end
         end
      end
   endtask

   // overlong first line saturates the run count, a few short lines follow
   task automatic send_crowded_rect();
      for (int k = 0; k < LONG_LINE_LEN; k++)
         drive_pixel(k[0] ? 8'hA5 : 8'h5A, k == LONG_LINE_LEN - 1, 1'b0, 1'b0, '0);
      for (int l = 0; l < EXTRA_LINES; l++)
         drive_pixel(PIX_W'($urandom_range(0, 255)), l != EXTRA_LINES - 1,
                     l == EXTRA_LINES - 1, 1'b0, '0);
   endtask

   // receiver: random stall, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      variance_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (variance_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected transaction: variance %0d lines %0d status %0d",
                        rsp_variance, rsp_lines_counted, rsp_status);
         end else begin
            exp_res = variance_queue.pop_front();
            if (rsp_variance !== exp_res.variance || rsp_lines_counted !== exp_res.lines ||
                rsp_status !== exp_res.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: expected variance %0d lines %0d status %0d, %s %0d %0d %0d",
                           exp_res.variance, exp_res.lines, exp_res.status,
                           "got", rsp_variance, rsp_lines_counted, rsp_status);
            end
         end
      end
   end

   // watchdog: too long with no transaction on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int phase_start;
      clear_rect_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_pixel(directed_rows[i].pixel, directed_rows[i].line_end,
                     directed_rows[i].rect_end, directed_rows[i].known,
                     directed_rows[i].result);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 50; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         phase_start = sent_items;
         if (phase == 1) send_crowded_rect();
         if (phase == 2) begin
            hold_req = 1'b1;
            repeat (4) send_random_rect();
            phase_start = sent_items;
         end
         while (sent_items - phase_start < PHASE_ITEMS) send_random_rect();
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && variance_queue.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rcdv_pkg.sv
hw/rtl/rcdv_datapath.sv
hw/rtl/rcdv_ctrl.sv
hw/rtl/run_count_difference_variance_top.sv
verif/run_count_difference_variance_top_tb.sv
